FILE: sv/http_chunked_body_decoder_macros.svh
// assertion helpers for the decoder back end
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication under reset
`define HCBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbd assertion failed");

// next-cycle implication under reset
`define HCBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbd assertion failed");

`endif

FILE: sv/hcbd_pkg.sv
package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int Q_DEPTH       = 2;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // one classified item on its way from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } item_t;

endpackage

FILE: sv/hcbd_front.sv
module hcbd_front (
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_start,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output hcbd_pkg::item_t push_item
);
  import hcbd_pkg::*;

  always_comb begin
    push_item         = '0;
    push_item.data    = in_byte;
    push_item.start   = in_start;
    push_item.is_cr   = (in_byte == CH_CR);
    push_item.is_lf   = (in_byte == CH_LF);
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      push_item.is_hex  = 1'b1;
      push_item.hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      // letters a-f and A-F share the low three bits pattern
      push_item.is_hex  = 1'b1;
      push_item.hex_val = 4'd9 + {1'b0, in_byte[2:0]};
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

FILE: sv/hcbd_queue.sv
module hcbd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hcbd_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output hcbd_pkg::item_t head
);
  import hcbd_pkg::*;

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);

  item_t            mem_r [Q_DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Q_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign full      = (cnt_r == CntW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

endmodule

FILE: sv/hcbd_back.sv
module hcbd_back #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  hcbd_pkg::item_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_status
);
  import hcbd_pkg::*;
  `include "http_chunked_body_decoder_macros.svh"

  typedef enum logic [3:0] {
    PH_SIZE, PH_EXT, PH_LF, PH_DATA, PH_SKIP1, PH_SKIP2, PH_DONE, PH_ERR
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                 digit_seen_r, digit_seen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic [1:0]           out_status_r, out_status_nxt;

  phase_t               ph;
  logic [SIZE_BITS-1:0] bl;
  logic                 ds;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic [1:0]           emit_status;

  assign pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    // a start flag restarts the parser before this byte is looked at
    ph          = head.start ? PH_SIZE : phase_r;
    bl          = head.start ? '0 : bytes_left_r;
    ds          = head.start ? 1'b0 : digit_seen_r;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_status = ST_BYTE;

    unique case (ph)
      PH_SIZE: begin
        if (head.is_hex) begin
          if (bl[SIZE_BITS-1 -: 4] != 4'd0) begin
            ph          = PH_ERR;
            emit        = 1'b1;
            emit_status = ST_ERROR;
          end else begin
            bl = {bl[SIZE_BITS-5:0], head.hex_val};
            ds = 1'b1;
          end
        end else if (!ds) begin
          ph          = PH_ERR;
          emit        = 1'b1;
          emit_status = ST_ERROR;
        end else begin
          ph = head.is_cr ? PH_LF : PH_EXT;
        end
      end
      PH_EXT: begin
        if (head.is_cr) ph = PH_LF;
      end
      PH_LF: begin
        if (head.is_lf) begin
          if (bl == '0) begin
            ph          = PH_DONE;
            emit        = 1'b1;
            emit_status = ST_DONE;
          end else begin
            ph = PH_DATA;
          end
        end else if (!head.is_cr) begin
          ph = PH_EXT;
        end
      end
      PH_DATA: begin
        if (bl == SIZE_BITS'(1)) ph = PH_SKIP1;
        bl        = bl - SIZE_BITS'(1);
        emit      = 1'b1;
        emit_byte = head.data;
      end
      PH_SKIP1: ph = PH_SKIP2;
      PH_SKIP2: begin
        ph = PH_SIZE;
        bl = '0;
        ds = 1'b0;
      end
      PH_DONE, PH_ERR: ;
      default: ph = PH_ERR;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    digit_seen_nxt = digit_seen_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    if (pop) begin
      phase_nxt      = ph;
      bytes_left_nxt = bl;
      digit_seen_nxt = ds;
      if (emit) begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = emit_byte;
        out_status_nxt = emit_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      bytes_left_r <= '0;
      digit_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      digit_seen_r <= digit_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

  `HCBD_ASSERT_IMP(a_data_nonzero, clk, rst_n, phase_r == PH_DATA, bytes_left_r != '0)
  `HCBD_ASSERT_IMP(a_nonbyte_zero, clk, rst_n, out_valid_r && out_status_r != ST_BYTE, out_byte_r == 8'd0)
  `HCBD_ASSERT_IMP(a_result_from_pop, clk, rst_n, $rose(out_valid_r), $past(pop))

endmodule

FILE: sv/http_chunked_body_decoder.sv
// an accepted byte is written into the queue, then its result into the output register
// throughput: one byte per cycle while out_tready stays high, set by the back-end parser state update
// a 2-entry queue decouples byte classification from the parser
// reset (synchronous, rst_n low): parser awaits size digits, queue and output empty
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] body_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser   // [1:0] status
);
  import hcbd_pkg::*;

  logic  q_full;
  logic  q_not_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t head;

  hcbd_front u_front (
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_start  (in_tuser[0]),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .push      (push),
    .push_item (push_item)
  );

  hcbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .out_status  (out_tuser)
  );

endmodule

FILE: dv/http_chunked_body_decoder_checker.sv
module http_chunked_body_decoder_checker #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [0:0] in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [1:0] out_tuser,
  output int         fail_count,
  output int         pending
);
  import hcbd_pkg::*;

  typedef enum logic [3:0] {
    AWAIT_SIZE, IN_EXT, WANT_LF, IN_DATA, SKIP_A, SKIP_B, FINISHED, FAILED
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } decoded_t;

  parse_phase_t         parse_phase;
  logic [SIZE_BITS-1:0] chunk_left;
  logic                 got_digit;
  decoded_t             decoded_q[$];
  int                   fails = 0;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function void new_size_line();
    parse_phase = AWAIT_SIZE;
    chunk_left  = '0;
    got_digit   = 1'b0;
  endfunction

  function void expect_result(input logic [7:0] d, input logic [1:0] s);
    decoded_t r;
    r.data   = d;
    r.status = s;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function void decode_byte(input logic [7:0] c, input logic restart);
    int h;
    h = nibble_of(c);
    if (restart) new_size_line();
    case (parse_phase)
      AWAIT_SIZE: begin
        if (h >= 0) begin
          // one more digit must fit in the size register
          if (chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
            parse_phase = FAILED;
            expect_result(8'd0, ST_ERROR);
          end else begin
            chunk_left = {chunk_left[SIZE_BITS-5:0], h[3:0]};
            got_digit  = 1'b1;
          end
        end else if (!got_digit) begin
          parse_phase = FAILED;
          expect_result(8'd0, ST_ERROR);
        end else if (c == CH_CR) begin
          parse_phase = WANT_LF;
        end else begin
          parse_phase = IN_EXT;
        end
      end
      IN_EXT: begin
        if (c == CH_CR) parse_phase = WANT_LF;
      end
      WANT_LF: begin
        if (c == CH_LF) begin
          if (chunk_left == '0) begin
            parse_phase = FINISHED;
            expect_result(8'd0, ST_DONE);
          end else begin
            parse_phase = IN_DATA;
          end
        end else if (c != CH_CR) begin
          parse_phase = IN_EXT;
        end
      end
      IN_DATA: begin
        chunk_left = chunk_left - SIZE_BITS'(1);
        if (chunk_left == '0) parse_phase = SKIP_A;
        expect_result(c, ST_BYTE);
      end
      SKIP_A: parse_phase = SKIP_B;
      SKIP_B: new_size_line();
      default: ;
    endcase
  endfunction

  function void check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      $error("result with no item pending: out_byte %0h status %0d", out_tdata, out_tuser);
      fails++;
    end else begin
      want = decoded_q.pop_front();
      if (out_tuser !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser);
        fails++;
      end
      if (out_tdata !== want.data) begin
        $error("out_byte mismatch: expected %0h, actual %0h", want.data, out_tdata);
        fails++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      new_size_line();
      decoded_q.delete();
    end else begin
      // results lag their bytes, so the oldest entry is matched first
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser[0]);
    end
    fail_count <= fails;
    pending    <= decoded_q.size();
  end

endmodule

FILE: dv/http_chunked_body_decoder_tb.sv
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          ITEM_TARGET = 1450;
  localparam int          SIZE_DIGITS = SIZE_BITS_DEF / 4;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;  // [7:0] in_byte
  logic [0:0] in_tuser   = 1'b0;  // [0] body_start
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [1:0] out_tuser;          // [1:0] status

  int          fail_count;
  int          pending;
  int          items_sent     = 0;
  int          in_idle_pct    = 0;
  int          out_idle_pct   = 0;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned cycle_count    = 0;
  logic [7:0]  msg_q[$];

  http_chunked_body_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  http_chunked_body_decoder_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin : receiver
    int hold;
    @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_tready <= 1'b0;
        for (hold = 0; hold < 150; hold++) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_item(msg_q[i], i == 0);
    items_sent += msg_q.size();
  endtask

  // random bytes after a message; the parser ignores them once it has completed or failed
  task automatic send_noise();
    repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1)) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic add_size_line(input logic [63:0] size);
    int nd;
    logic [7:0] b;
    nd = 1;
    while (nd < 16 && (size >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 12)) add_byte("0");
    for (int i = nd - 1; i >= 0; i--) add_byte(hex_char(int'((size >> (4 * i)) & 64'hF)));
    if ($urandom_range(0, 9) < 3) begin
      // extension must open with a non-digit so it cannot extend the size
      add_byte($urandom_range(0, 1) ? ";" : " ");
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        add_byte(b == CH_LF ? 8'(";") : b);
      end
    end
    case ($urandom_range(0, 9))
      0: add_byte(CH_CR);
      1: begin
        add_byte(CH_CR);
        add_byte("x");
      end
      default: ;
    endcase
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic add_chunk(input int unsigned size);
    add_size_line(64'(size));
    repeat (size) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 85) begin
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_message();
    int unsigned v;
    int unsigned k;
    msg_q.delete();
    repeat ($urandom_range(0, 4)) add_chunk(pick_size());
    v = $urandom_range(0, 99);
    if (v < 82) begin
      add_size_line(64'd0);
    end else if (v < 88) begin
      // size line without any digit
      case ($urandom_range(0, 4))
        0: add_byte(CH_CR);
        1: add_byte(CH_LF);
        2: add_byte(" ");
        3: add_byte("g");
        default: add_byte(8'($urandom_range(128, 255)));
      endcase
    end else if (v < 93) begin
      add_byte(hex_char($urandom_range(1, 15)));
      repeat (SIZE_DIGITS) add_byte(hex_char($urandom_range(0, 15)));
    end else begin
      // largest legal size, cut short by the next restart
      add_size_line((64'd1 << SIZE_BITS_DEF) - 1);
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end
    if (msg_q.size() > 1 && $urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > k) void'(msg_q.pop_back());
    end
  endtask

  initial begin : stimulus
    int msg_count;
    msg_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    msg_q.delete();
    queue_text("0\r\n");
    send_message();
    msg_q.delete();
    add_byte(CH_CR);
    add_byte("5");
    send_message();
    msg_q.delete();
    queue_text("2;\rx\r\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    queue_text("\r\n0\r\n");
    send_message();
    msg_q.delete();
    queue_text("ffFFffFFf");
    send_message();
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      msg_count++;
      if (items_sent > ITEM_TARGET - 200) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else if (msg_count % 6 == 1) begin
        case ($urandom_range(0, 2))
          0: in_idle_pct = 0;
          1: in_idle_pct = 5;
          default: in_idle_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: out_idle_pct = 0;
          1: out_idle_pct = 5;
          default: out_idle_pct = 25;
        endcase
      end
      if (msg_count == 10) begin
        // long output stall while a big chunk is offered with no input idles
        in_idle_pct   = 0;
        long_hold_req = 1'b1;
        msg_q.delete();
        add_chunk(200);
        queue_text("0\r\n");
      end else begin
        build_message();
      end
      send_message();
      if ($urandom_range(0, 3) == 0) send_noise();
      if (msg_count % 15 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/hcbd_pkg.sv
sv/hcbd_front.sv
sv/hcbd_queue.sv
sv/hcbd_back.sv
sv/http_chunked_body_decoder.sv
dv/http_chunked_body_decoder_checker.sv
dv/http_chunked_body_decoder_tb.sv
